/* hdl/obl_pkg.sv */
package obl_pkg;

	localparam int LEVELS_DEF = 256;
	localparam int PRICE_W    = 52;
	localparam int VOLUME_W   = 52;
	localparam int ID_W       = 63;

	typedef enum logic [1:0] {
		STS_APPLIED = 2'd0,
		STS_GAP     = 2'd1,
		STS_DROPPED = 2'd2,
		STS_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_APPLY  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

/* hdl/obl_ram.sv */
module obl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/order_book_level_cache.sv */
// Order book price level cache.
// Input channel (in_valid / in_stall) carries one transaction per level update
// or clear command; output channel (out_valid / out_stall) returns one result
// transaction per input: status, best bid and best ask with valid flags, and
// the stored update id.
// A level update scans its side's price table once, one entry per cycle
// through the registered read port of that table's RAM, finding the matching
// or first free entry while recomputing that side's best price. The update
// then passes through the apply and finish states; out_valid rises as the
// block returns to idle, and only then can the next item be accepted.
// Clear commands, rejected and dropped items and items without a level go
// straight to the finish state, where out_valid is raised. One item is
// worked on at a time; in_stall is high while an item is in flight.
// The result waits in an output register; if out_stall is held the block
// finishes the next item and then holds until the output register is free.
// Reset empties both tables (used bits are flip-flops cleared at once),
// zeroes the stored id and the reject flag; no clearing pass is needed.
module order_book_level_cache #(
	parameter int LEVELS = obl_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [obl_pkg::ID_W-1:0]     update_id,
	input  logic                         first_in_batch,
	input  logic                         skip_check,
	input  logic                         has_level,
	input  logic                         side,
	input  logic [obl_pkg::PRICE_W-1:0]  price,
	input  logic [obl_pkg::VOLUME_W-1:0] volume,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [obl_pkg::PRICE_W-1:0]  best_bid,
	output logic                         bid_valid,
	output logic [obl_pkg::PRICE_W-1:0]  best_ask,
	output logic                         ask_valid,
	output logic [obl_pkg::ID_W-1:0]     applied_id
);
	import obl_pkg::*;

	localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(LEVELS - 1);

	state_t state_q;
	logic [LEVELS-1:0] ask_used_q, bid_used_q;
	logic [ID_W-1:0] last_id_q, uid_q;
	logic rej_q;
	logic [PRICE_W-1:0] bb_q, ba_q, price_q, best_q;
	logic bv_q, av_q, best_found_q;
	logic side_q, vol_nz_q;
	status_t sts_q;
	logic [IW-1:0] cnt_q, idx_s1, match_idx_q, free_idx_q;
	logic issue_q, rd_s1, match_q, free_q;

	logic [PRICE_W-1:0] ask_rd, bid_rd, rd_price;
	logic used_s1, ram_we_ask, ram_we_bid, accept, gap, better_rd, incl, better_new;
	logic [PRICE_W-1:0] new_best;
	logic new_found;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign gap = first_in_batch && !skip_check && (last_id_q != '0) &&
		(update_id != ID_W'(last_id_q + 1'b1));

	assign rd_price = side_q ? bid_rd : ask_rd;
	assign used_s1 = side_q ? bid_used_q[idx_s1] : ask_used_q[idx_s1];
	assign better_rd = side_q ? (rd_price > best_q) : (rd_price < best_q);

	assign incl = vol_nz_q && (match_q || free_q);
	assign better_new = side_q ? (price_q > best_q) : (price_q < best_q);
	assign new_best = (incl && (!best_found_q || better_new)) ? price_q : best_q;
	assign new_found = best_found_q || incl;

	assign ram_we_ask = (state_q == ST_APPLY) && !side_q && vol_nz_q && !match_q && free_q;
	assign ram_we_bid = (state_q == ST_APPLY) && side_q && vol_nz_q && !match_q && free_q;

	obl_ram #(.WIDTH(PRICE_W), .DEPTH(LEVELS)) u_ask_ram (
		.clk(clk), .we(ram_we_ask), .waddr(free_idx_q), .wdata(price_q),
		.raddr(cnt_q), .rdata(ask_rd)
	);

	obl_ram #(.WIDTH(PRICE_W), .DEPTH(LEVELS)) u_bid_ram (
		.clk(clk), .we(ram_we_bid), .waddr(free_idx_q), .wdata(price_q),
		.raddr(cnt_q), .rdata(bid_rd)
	);

	// Payload registers of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			uid_q <= update_id;
			side_q <= side;
			price_q <= price;
			vol_nz_q <= (volume != '0);
			best_q <= '0;
		end
		idx_s1 <= cnt_q;
		if (state_q == ST_SCAN && rd_s1) begin
			if (used_s1) begin
				if (rd_price == price_q) begin
					match_idx_q <= idx_s1;
				end else if (!best_found_q || better_rd) begin
					best_q <= rd_price;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ask_used_q <= '0;
			bid_used_q <= '0;
			last_id_q <= '0;
			rej_q <= 1'b0;
			bb_q <= '0;
			ba_q <= '0;
			bv_q <= 1'b0;
			av_q <= 1'b0;
			sts_q <= STS_APPLIED;
			cnt_q <= '0;
			issue_q <= 1'b0;
			rd_s1 <= 1'b0;
			match_q <= 1'b0;
			free_q <= 1'b0;
			best_found_q <= 1'b0;
			out_valid <= 1'b0;
			status <= '0;
			best_bid <= '0;
			bid_valid <= 1'b0;
			best_ask <= '0;
			ask_valid <= 1'b0;
			applied_id <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_FINISH) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sts_q <= STS_APPLIED;
						state_q <= ST_FINISH;
						if (opcode) begin
							ask_used_q <= '0;
							bid_used_q <= '0;
							last_id_q <= '0;
							rej_q <= 1'b0;
							bb_q <= '0;
							ba_q <= '0;
							bv_q <= 1'b0;
							av_q <= 1'b0;
						end else if (first_in_batch && gap) begin
							rej_q <= 1'b1;
							sts_q <= STS_GAP;
						end else if (!first_in_batch && rej_q) begin
							sts_q <= STS_DROPPED;
						end else begin
							if (first_in_batch) begin
								rej_q <= 1'b0;
							end
							if (has_level) begin
								state_q <= ST_SCAN;
								cnt_q <= '0;
								issue_q <= 1'b1;
								match_q <= 1'b0;
								free_q <= 1'b0;
								best_found_q <= 1'b0;
							end else begin
								last_id_q <= update_id;
							end
						end
					end
				end
				ST_SCAN: begin
					rd_s1 <= issue_q;
					if (issue_q) begin
						if (cnt_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (rd_s1) begin
						if (used_s1) begin
							if (rd_price == price_q) begin
								match_q <= 1'b1;
							end else begin
								best_found_q <= 1'b1;
							end
						end else begin
							free_q <= 1'b1;
						end
					end
					if (!issue_q && !rd_s1) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					last_id_q <= uid_q;
					if (match_q && !vol_nz_q) begin
						if (side_q) begin
							bid_used_q[match_idx_q] <= 1'b0;
						end else begin
							ask_used_q[match_idx_q] <= 1'b0;
						end
					end else if (!match_q && vol_nz_q) begin
						if (free_q) begin
							if (side_q) begin
								bid_used_q[free_idx_q] <= 1'b1;
							end else begin
								ask_used_q[free_idx_q] <= 1'b1;
							end
						end else begin
							sts_q <= STS_FULL;
						end
					end
					if (side_q) begin
						bb_q <= new_found ? new_best : '0;
						bv_q <= new_found;
					end else begin
						ba_q <= new_found ? new_best : '0;
						av_q <= new_found;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// A result leaving this cycle is replaced in place by the new one.
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						status <= sts_q;
						best_bid <= bb_q;
						bid_valid <= bv_q;
						best_ask <= ba_q;
						ask_valid <= av_q;
						applied_id <= last_id_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

	a_bid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bid_valid) |-> (best_bid == '0))
		else $error("best bid nonzero with empty bid table");

	a_ask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ask_valid) |-> (best_ask == '0))
		else $error("best ask nonzero with empty ask table");

	a_apply_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> (state_q == ST_FINISH))
		else $error("apply step not followed by finish");

endmodule

/* verif/order_book_level_cache_tb.sv */
module order_book_level_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import obl_pkg::*;

	localparam int N_LEVELS = LEVELS_DEF;
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;
	localparam logic SIDE_ASK  = 1'b0;
	localparam logic SIDE_BID  = 1'b1;

	typedef struct packed {
		status_t              sts;
		logic [PRICE_W-1:0]   bid;
		logic                 bid_ok;
		logic [PRICE_W-1:0]   ask;
		logic                 ask_ok;
		logic [ID_W-1:0]      id;
	} book_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_UPDATE;
	logic [ID_W-1:0] update_id = '0;
	logic first_in_batch = 1'b0;
	logic skip_check = 1'b0;
	logic has_level = 1'b0;
	logic side = SIDE_ASK;
	logic [PRICE_W-1:0] price = '0;
	logic [VOLUME_W-1:0] volume = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [PRICE_W-1:0] best_bid;
	logic bid_valid;
	logic [PRICE_W-1:0] best_ask;
	logic ask_valid;
	logic [ID_W-1:0] applied_id;

	order_book_level_cache uut (.*);

	always #1 clk = ~clk;

	// Shadow copy of the book.
	logic [PRICE_W-1:0]  sh_price [2][N_LEVELS];
	logic [VOLUME_W-1:0] sh_vol   [2][N_LEVELS];
	logic                sh_used  [2][N_LEVELS];
	logic [ID_W-1:0]     sh_last_id;
	logic                sh_rejected;

	book_view_t pending_views[$];
	int errors = 0;
	bit hold_receiver = 0;
	bit long_hold = 0;
	logic [ID_W-1:0] next_id;

	function automatic void clear_book();
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < N_LEVELS; i++) begin
				sh_used[s][i] = 1'b0;
				sh_price[s][i] = '0;
				sh_vol[s][i] = '0;
			end
		sh_last_id = '0;
		sh_rejected = 1'b0;
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom);
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		return ID_W'({$urandom, $urandom});
	endfunction

	function automatic logic [PRICE_W-1:0] rand_wide();
		return PRICE_W'({$urandom, $urandom});
	endfunction

	function automatic status_t write_level(int s, logic [PRICE_W-1:0] p,
			logic [VOLUME_W-1:0] v);
		int free_i;
		free_i = -1;
		for (int i = 0; i < N_LEVELS; i++) begin
			if (sh_used[s][i]) begin
				if (sh_price[s][i] == p) begin
					if (v == 0) sh_used[s][i] = 1'b0;
					else sh_vol[s][i] = v;
					return STS_APPLIED;
				end
			end else if (free_i < 0) begin
				free_i = i;
			end
		end
		if (v == 0) return STS_APPLIED;
		if (free_i < 0) return STS_FULL;
		sh_price[s][free_i] = p;
		sh_vol[s][free_i] = v;
		sh_used[s][free_i] = 1'b1;
		return STS_APPLIED;
	endfunction

	function automatic book_view_t predict_book(logic op, logic [ID_W-1:0] uid,
			logic first, logic skip, logic lvl, logic sd, logic [PRICE_W-1:0] p,
			logic [VOLUME_W-1:0] v);
		book_view_t r;
		bit go;
		r = '0;
		r.sts = STS_APPLIED;
		if (op == OP_CLEAR) begin
			clear_book();
		end else begin
			go = 1;
			if (first) begin
				if (!skip && sh_last_id != 0 && uid != ID_W'(sh_last_id + 1)) begin
					sh_rejected = 1'b1;
					r.sts = STS_GAP;
					go = 0;
				end else begin
					sh_rejected = 1'b0;
				end
			end else if (sh_rejected) begin
				r.sts = STS_DROPPED;
				go = 0;
			end
			if (go) begin
				if (lvl) r.sts = write_level(sd, p, v);
				sh_last_id = uid;
			end
		end
		for (int i = 0; i < N_LEVELS; i++) begin
			if (sh_used[SIDE_BID][i] && (!r.bid_ok || sh_price[SIDE_BID][i] > r.bid)) begin
				r.bid = sh_price[SIDE_BID][i];
				r.bid_ok = 1'b1;
			end
			if (sh_used[SIDE_ASK][i] && (!r.ask_ok || sh_price[SIDE_ASK][i] < r.ask)) begin
				r.ask = sh_price[SIDE_ASK][i];
				r.ask_ok = 1'b1;
			end
		end
		r.id = sh_last_id;
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return int'($urandom_range(20, 300));
		return int'($urandom_range(0, 3));
	endfunction

	// Sends one transaction and records its expected result at acceptance.
	task automatic send_item(logic op, logic [ID_W-1:0] uid, logic first, logic skip,
			logic lvl, logic sd, logic [PRICE_W-1:0] p, logic [VOLUME_W-1:0] v,
			bit idle = 1'b1);
		int g;
		book_view_t view;
		g = idle ? gap_len() : 0;
		repeat (g) @(negedge clk);
		in_valid = 1'b1;
		opcode = op;
		update_id = uid;
		first_in_batch = first;
		skip_check = skip;
		has_level = lvl;
		side = sd;
		price = p;
		volume = v;
		do @(posedge clk); while (in_stall);
		view = predict_book(op, uid, first, skip, lvl, sd, p, v);
		pending_views.insert(pending_views.size(), view);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_level(logic first, logic sd, logic [PRICE_W-1:0] p,
			logic [VOLUME_W-1:0] v);
		if (first) next_id = next_id + 1'b1;
		send_item(OP_UPDATE, next_id, first, 1'b0, 1'b1, sd, p, v);
	endtask

	task automatic wait_drained();
		while (pending_views.size() != 0) @(negedge clk);
		repeat (2 * N_LEVELS + 20) @(negedge clk);
	endtask

	// Receiver stall pattern.
	always @(negedge clk) begin
		if (hold_receiver) out_stall <= 1'b1;
		else if ($urandom_range(0, 3) == 0) out_stall <= 1'b1;
		else out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		book_view_t e, a;
		if (out_valid && !out_stall) begin
			a.sts = status_t'(status);
			a.bid = best_bid;
			a.bid_ok = bid_valid;
			a.ask = best_ask;
			a.ask_ok = ask_valid;
			a.id = applied_id;
			if (pending_views.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result %p", a);
			end else begin
				e = pending_views.pop_front();
				if (e !== a) begin
					errors++;
					if (errors <= 10) $display("Mismatch: expected %p, actual %p", e, a);
				end
			end
		end
	end

	// Long receiver hold counted in cycles while the sender keeps offering items.
	always @(negedge clk) begin
		if (long_hold) begin
			hold_receiver = 1;
			repeat (3000) @(negedge clk);
			hold_receiver = 0;
			long_hold = 0;
		end
	end

	task automatic test_clear_and_extremes();
		logic [PRICE_W-1:0] pmax;
		pmax = '1;
		send_item(OP_CLEAR, '1, 1'b1, 1'b1, 1'b1, SIDE_BID, pmax, '1);
		// Stored id zero lets any first id in.
		send_item(OP_UPDATE, '1, 1'b1, 1'b0, 1'b1, SIDE_BID, pmax, '1);
		// Wrap of the id to zero is in sequence.
		send_item(OP_UPDATE, '0, 1'b1, 1'b0, 1'b1, SIDE_ASK, '0, VOLUME_W'(1));
		send_item(OP_UPDATE, '0, 1'b0, 1'b0, 1'b1, SIDE_ASK, pmax, '1);
		send_item(OP_UPDATE, ID_W'(5), 1'b1, 1'b1, 1'b1, SIDE_BID, '0, VOLUME_W'(1));
		send_item(OP_UPDATE, ID_W'(5), 1'b0, 1'b0, 1'b1, SIDE_BID, pmax, '0);
		send_item(OP_UPDATE, ID_W'(5), 1'b0, 1'b0, 1'b1, SIDE_BID, PRICE_W'(12345), '0);
		send_item(OP_UPDATE, ID_W'(6), 1'b1, 1'b0, 1'b0, SIDE_ASK, PRICE_W'(7),
			VOLUME_W'(7));
		send_item(OP_UPDATE, ID_W'(9), 1'b1, 1'b0, 1'b1, SIDE_ASK, PRICE_W'(7),
			VOLUME_W'(7));
		send_item(OP_UPDATE, ID_W'(9), 1'b0, 1'b0, 1'b1, SIDE_ASK, PRICE_W'(8),
			VOLUME_W'(8));
		send_item(OP_UPDATE, ID_W'(9), 1'b0, 1'b1, 1'b0, SIDE_BID, PRICE_W'(8),
			VOLUME_W'(8));
		send_item(OP_UPDATE, ID_W'(7), 1'b1, 1'b0, 1'b1, SIDE_ASK, PRICE_W'(9),
			VOLUME_W'(9));
		send_item(OP_UPDATE, ID_W'(7), 1'b0, 1'b0, 1'b1, SIDE_ASK, PRICE_W'(9),
			VOLUME_W'(10));
		send_item(OP_CLEAR, '0, 1'b0, 1'b0, 1'b0, SIDE_ASK, '0, '0);
	endtask

	task automatic test_table_full();
		next_id = ID_W'(100);
		send_item(OP_UPDATE, next_id, 1'b1, 1'b1, 1'b0, SIDE_ASK, '0, '0, 1'b0);
		for (int i = 0; i < N_LEVELS + 2; i++)
			send_item(OP_UPDATE, next_id, 1'b0, 1'b0, 1'b1, SIDE_BID, PRICE_W'(1000 + i),
				VOLUME_W'(1 + i), 1'b0);
		send_item(OP_UPDATE, next_id, 1'b0, 1'b0, 1'b1, SIDE_BID, PRICE_W'(1000), '0);
		send_item(OP_UPDATE, next_id, 1'b0, 1'b0, 1'b1, SIDE_BID, PRICE_W'(5),
			VOLUME_W'(5));
		send_item(OP_UPDATE, next_id, 1'b0, 1'b0, 1'b1, SIDE_BID, PRICE_W'(6),
			VOLUME_W'(6));
		send_item(OP_CLEAR, '0, 1'b0, 1'b0, 1'b0, SIDE_ASK, '0, '0);
	endtask

	task automatic test_backpressure();
		long_hold = 1;
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			send_item(OP_UPDATE, '0, 1'b0, 1'b0, 1'b1, i[0], PRICE_W'(i), VOLUME_W'(i),
				1'b0);
		wait_drained();
	endtask

	task automatic test_random_batches();
		logic [PRICE_W-1:0] p;
		logic [VOLUME_W-1:0] v;
		logic [ID_W-1:0] uid;
		int n, k;
		next_id = rand_id();
		n = 0;
		while (n < 1700) begin
			k = $urandom_range(0, 15);
			if (k == 0) begin
				send_item(OP_CLEAR, rand_id(), rand_bit(), rand_bit(), rand_bit(),
					rand_bit(), rand_wide(), rand_wide());
				n++;
				continue;
			end
			if (k == 1) begin
				// Broken sequence: gap in ids.
				uid = next_id + ID_W'($urandom_range(2, 1000));
				send_item(OP_UPDATE, uid, 1'b1, 1'b0, rand_bit(), rand_bit(),
					PRICE_W'($urandom), VOLUME_W'($urandom));
			end else if (k == 2) begin
				next_id = rand_id();
				send_item(OP_UPDATE, next_id, 1'b1, 1'b1, rand_bit(), rand_bit(),
					PRICE_W'($urandom_range(1, 64)), VOLUME_W'($urandom));
			end else begin
				send_level(1'b1, rand_bit(), PRICE_W'($urandom_range(1, 64)),
					VOLUME_W'($urandom_range(0, 3)));
			end
			n++;
			repeat ($urandom_range(0, 8)) begin
				if ($urandom_range(0, 9) == 0) p = rand_wide();
				else p = PRICE_W'($urandom_range(1, 64));
				if ($urandom_range(0, 3) == 0) v = '0;
				else if ($urandom_range(0, 9) == 0) v = rand_wide();
				else v = VOLUME_W'($urandom_range(1, 1000));
				send_level(1'b0, rand_bit(), p, v);
				n++;
			end
			if ($urandom_range(0, 199) == 0) wait_drained();
		end
	endtask

	initial begin
		clear_book();
		next_id = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_clear_and_extremes();
		test_table_full();
		test_backpressure();
		test_random_batches();
		wait_drained();
		if (errors == 0 && pending_views.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/obl_pkg.sv
hdl/obl_ram.sv
hdl/order_book_level_cache.sv
verif/order_book_level_cache_tb.sv
